/* rtl/foc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// foc_pkg
// Shared constants, table generators and types for the Clarke/Park step.
// ----------------------------------------------------------------------------
package foc_pkg;

	localparam int ATAN_TABLE_SIZE = 102;
	localparam int SINE_TABLE_SIZE = 1024;

	localparam int ATAN_STEPS = ATAN_TABLE_SIZE - 2;
	localparam int ATAN_IW    = $clog2(ATAN_TABLE_SIZE);
	localparam int SIN_AW     = $clog2(SINE_TABLE_SIZE);
	localparam int SIN_QTR    = SINE_TABLE_SIZE / 4;
	localparam int ATAN_SCALE = ATAN_STEPS * 65536;
	localparam int DIV_QW     = $clog2(ATAN_SCALE + 1);
	localparam int DIV_DW     = 35;
	localparam int DIV_NW     = 33 + DIV_QW;
	localparam int PIPE_DEPTH = DIV_QW + 8;
	localparam int VOLT_FULL2 = 2 * 20480;
	localparam int HALF_PI_Q16 = 102944;

	localparam logic [63:0] Q30_ONE        = 64'd1073741824;
	localparam logic [63:0] PI_Q30         = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] TWO_PI_Q30     = 64'd6746518852;
	localparam logic signed [63:0] QUARTER_PI_Q30 = 64'sd843314857;

	typedef logic signed [15:0] sine_rom_t [SINE_TABLE_SIZE];
	typedef logic [15:0] atan_rom_t [ATAN_TABLE_SIZE];

	typedef struct packed {
		logic zero;
		logic neg_a;
		logic neg_b;
		logic swap;
	} foc_side_t;

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [15:0] sine_entry(input logic [63:0] k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] sm;
		logic neg;
		x = udiv64(k * TWO_PI_Q30, 64'(SINE_TABLE_SIZE));
		neg = 1'b0;
		if (x >= PI_Q30) begin
			neg = 1'b1;
			x = x - PI_Q30;
		end
		if (x > HALF_PI_Q30) x = PI_Q30 - x;
		x2 = (x * x) >> 30;
		t = x;
		sm = $signed(x);
		for (int n = 1; n <= 8; n++) begin
			t = udiv64((t * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
			if ((n & 1) != 0) sm = sm - $signed(t);
			else sm = sm + $signed(t);
		end
		if (sm < 0) sm = 64'sd0;
		sm = (sm + 64'sd32768) >>> 16;
		return neg ? -16'(sm) : 16'(sm);
	endfunction

	function automatic logic signed [63:0] atan_series(input logic [63:0] y);
		logic [63:0] y2;
		logic [63:0] p;
		logic signed [63:0] sm;
		y2 = (y * y) >> 30;
		p = y;
		sm = $signed(y);
		for (int n = 1; n <= 14; n++) begin
			p = (p * y2) >> 30;
			if ((n & 1) != 0) sm = sm - $signed(udiv64(p, 64'(2 * n + 1)));
			else sm = sm + $signed(udiv64(p, 64'(2 * n + 1)));
		end
		return sm;
	endfunction

	function automatic logic [15:0] atan_entry(input logic [63:0] k);
		logic [63:0] s;
		logic signed [63:0] v;
		s = 64'(ATAN_STEPS);
		if (5 * k <= 2 * s) v = atan_series(udiv64(k * Q30_ONE, s));
		else if (k <= s) v = QUARTER_PI_Q30 - atan_series(udiv64((s - k) * Q30_ONE, s + k));
		else v = QUARTER_PI_Q30 + atan_series(udiv64((k - s) * Q30_ONE, k + s));
		if (v < 0) v = 64'sd0;
		return 16'((v + 64'sd8192) >>> 14);
	endfunction

	function automatic sine_rom_t gen_sine();
		sine_rom_t r;
		for (int k = 0; k < SINE_TABLE_SIZE; k++) r[k] = sine_entry(64'(k));
		return r;
	endfunction

	function automatic atan_rom_t gen_atan();
		atan_rom_t r;
		for (int k = 0; k < ATAN_TABLE_SIZE; k++) r[k] = atan_entry(64'(k));
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/foc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// foc_in_if
// Current sample channel: three phase currents, rotor angle, torque target.
// ----------------------------------------------------------------------------
interface foc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] current_a;
	logic signed [15:0] current_b;
	logic signed [15:0] current_c;
	logic        [15:0] rotor_angle;
	logic        [13:0] torque_target;

	modport source (output valid, current_a, current_b, current_c, rotor_angle,
		torque_target, input ready);
	modport sink (input valid, current_a, current_b, current_c, rotor_angle,
		torque_target, output ready);
endinterface
`default_nettype wire

/* rtl/foc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// foc_out_if
// Voltage vector channel: normalized alpha/beta, space angle, zero flag.
// ----------------------------------------------------------------------------
interface foc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] volt_alpha;
	logic signed [15:0] volt_beta;
	logic signed [14:0] space_angle;
	logic               zero_vector;

	modport source (output valid, volt_alpha, volt_beta, space_angle, zero_vector,
		input ready);
	modport sink (input valid, volt_alpha, volt_beta, space_angle, zero_vector,
		output ready);
endinterface
`default_nettype wire

/* rtl/foc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// foc_div
// Pipelined restoring divider, one quotient bit per stage, per-stage enable.
// ----------------------------------------------------------------------------
module foc_div (
	input  wire logic                        clk,
	input  wire logic [foc_pkg::DIV_QW-1:0]  en,
	input  wire logic [foc_pkg::DIV_NW-1:0]  num,
	input  wire logic [foc_pkg::DIV_DW-1:0]  den,
	output logic      [foc_pkg::DIV_QW-1:0]  quo
);
	import foc_pkg::*;

	logic [DIV_NW-1:0] rem_sd [DIV_QW];
	logic [DIV_DW-1:0] den_sd [DIV_QW];
	logic [DIV_QW-1:0] quo_sd [DIV_QW];

	for (genvar j = 0; j < DIV_QW; j++) begin : g_stage
		localparam int B = DIV_QW - 1 - j;
		logic [DIV_NW-1:0] rem_in;
		logic [DIV_DW-1:0] den_in;
		logic [DIV_QW-1:0] quo_in;
		logic              fit;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sd[j-1];
			assign den_in = den_sd[j-1];
			assign quo_in = quo_sd[j-1];
		end

		assign fit = (rem_in >> B) >= DIV_NW'(den_in);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_sd[j] <= fit ? rem_in - (DIV_NW'(den_in) << B) : rem_in;
				den_sd[j] <= den_in;
				quo_sd[j] <= quo_in | (DIV_QW'(fit) << B);
			end
		end
	end

	assign quo = quo_sd[DIV_QW-1];
endmodule
`default_nettype wire

/* rtl/field_oriented_control_step_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// field_oriented_control_step_top
// Clarke, Park, proportional rule, inverse Park, magnitude normalization and
// interpolated arctangent of the resulting voltage vector.
// ----------------------------------------------------------------------------
//  channel  role    beat contents
//  sample   sink    current_a/b/c, rotor_angle, torque_target
//  result   source  volt_alpha, volt_beta, space_angle, zero_vector
//
//  One beat per cycle is accepted unless a full pipeline stalls; a beat passes s1-s6,
//  the bit-per-stage dividers for the scaling and arctangent ratio, s7 and s8.
//  Each stage moves when it is empty or the stage after it moves, so bubbles
//  close up under a stall. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module field_oriented_control_step_top (
	input  wire logic clk,
	input  wire logic arst_n,
	foc_in_if.sink    sample,
	foc_out_if.source result
);
	import foc_pkg::*;

	localparam int ST_DIV = 6;
	localparam int ST_S7  = ST_DIV + DIV_QW;
	localparam int ST_S8  = ST_S7 + 1;

	localparam sine_rom_t SINE_ROM = gen_sine();
	localparam atan_rom_t ATAN_ROM = gen_atan();

	localparam logic signed [16:0] INV_SQRT6 = 17'sd26755;
	localparam logic signed [16:0] INV_SQRT2 = 17'sd46341;

	function automatic logic signed [35:0] rnd_sh(input logic signed [35:0] v,
			input int sh);
		logic [35:0] m;
		m = (v < 0) ? 36'(-v) : 36'(v);
		m = (m + (36'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -$signed(m) : $signed(m);
	endfunction

	logic [PIPE_DEPTH-1:0] vld_q;
	logic [PIPE_DEPTH-1:0] en;

	for (genvar j = 0; j < PIPE_DEPTH; j++) begin : g_ctl
		assign en[j] = result.ready || !(&vld_q[PIPE_DEPTH-1:j]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en[j]) begin
				if (j == 0) vld_q[j] <= sample.valid;
				else vld_q[j] <= vld_q[(j == 0) ? 0 : j - 1];
			end
		end
	end

	assign sample.ready = en[0];

	// s1: Clarke and sine/cosine lookup
	logic signed [17:0] d_alpha;
	logic signed [16:0] d_beta;
	logic [SIN_AW-1:0]  k_sin;
	logic [SIN_AW:0]    k_sum;
	logic [SIN_AW-1:0]  k_cos;
	logic [28:0]        k_prod;

	assign d_alpha = (18'(sample.current_a) <<< 1) - 18'(sample.current_b)
		- 18'(sample.current_c);
	assign d_beta  = 17'(sample.current_b) - 17'(sample.current_c);
	assign k_prod  = 29'(sample.rotor_angle) * 29'(SINE_TABLE_SIZE);
	assign k_sin   = SIN_AW'(k_prod >> 16);
	assign k_sum   = (SIN_AW+1)'(k_sin) + (SIN_AW+1)'(SIN_QTR);
	assign k_cos   = (k_sum >= (SIN_AW+1)'(SINE_TABLE_SIZE))
		? SIN_AW'(k_sum - (SIN_AW+1)'(SINE_TABLE_SIZE)) : SIN_AW'(k_sum);

	logic signed [16:0] alpha_s1, beta_s1;
	logic signed [15:0] sn_s1, cs_s1;
	logic        [13:0] tq_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			alpha_s1 <= 17'(rnd_sh(36'(d_alpha) * 36'(INV_SQRT6), 16));
			beta_s1  <= 17'(rnd_sh(36'(d_beta) * 36'(INV_SQRT2), 16));
			sn_s1    <= SINE_ROM[k_sin];
			cs_s1    <= SINE_ROM[k_cos];
			tq_s1    <= sample.torque_target;
		end
	end

	// s2: Park products
	logic signed [32:0] p_ca_s2, p_sb_s2, p_cb_s2, p_sa_s2;
	logic signed [15:0] sn_s2, cs_s2;
	logic        [13:0] tq_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_ca_s2 <= 33'(cs_s1) * 33'(alpha_s1);
			p_sb_s2 <= 33'(sn_s1) * 33'(beta_s1);
			p_cb_s2 <= 33'(cs_s1) * 33'(beta_s1);
			p_sa_s2 <= 33'(sn_s1) * 33'(alpha_s1);
			sn_s2   <= sn_s1;
			cs_s2   <= cs_s1;
			tq_s2   <= tq_s1;
		end
	end

	// s3: id/iq rounding and proportional rule
	logic signed [18:0] id_w, iq_w;
	logic signed [18:0] vd_s3, vq_s3;
	logic signed [15:0] sn_s3, cs_s3;

	assign id_w = 19'(rnd_sh(36'(p_ca_s2) + 36'(p_sb_s2), 14));
	assign iq_w = 19'(rnd_sh(36'(p_cb_s2) - 36'(p_sa_s2), 14));

	always_ff @(posedge clk) begin
		if (en[2]) begin
			vd_s3 <= -id_w;
			vq_s3 <= $signed({4'b0, tq_s2, 1'b0}) - iq_w;
			sn_s3 <= sn_s2;
			cs_s3 <= cs_s2;
		end
	end

	// s4: inverse Park products
	logic signed [34:0] p_dc_s4, p_qs_s4, p_ds_s4, p_qc_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			p_dc_s4 <= 35'(vd_s3) * 35'(cs_s3);
			p_qs_s4 <= 35'(vq_s3) * 35'(sn_s3);
			p_ds_s4 <= 35'(vd_s3) * 35'(sn_s3);
			p_qc_s4 <= 35'(vq_s3) * 35'(cs_s3);
		end
	end

	// s5: voltages, magnitudes
	logic signed [35:0] va_w, vb_w;
	logic [32:0] ma_s5, mb_s5;
	logic [33:0] sum_s5;
	logic        na_s5, nb_s5;

	assign va_w = 36'(p_dc_s4) - 36'(p_qs_s4);
	assign vb_w = 36'(p_ds_s4) + 36'(p_qc_s4);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ma_s5  <= (va_w < 0) ? 33'(-va_w) : 33'(va_w);
			mb_s5  <= (vb_w < 0) ? 33'(-vb_w) : 33'(vb_w);
			sum_s5 <= ((va_w < 0) ? 34'(-va_w) : 34'(va_w))
				+ ((vb_w < 0) ? 34'(-vb_w) : 34'(vb_w));
			na_s5  <= va_w < 0;
			nb_s5  <= vb_w < 0;
		end
	end

	// s6: divider operands
	logic              swap_w;
	logic [32:0]       mn_w, mx_w;
	logic [DIV_NW-1:0] num_a_s6, num_b_s6, num_t_s6;
	logic [DIV_DW-1:0] den_v_s6, den_t_s6;
	foc_side_t         side_s6;

	assign swap_w = mb_s5 > ma_s5;
	assign mn_w   = swap_w ? ma_s5 : mb_s5;
	assign mx_w   = swap_w ? mb_s5 : ma_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			num_a_s6 <= DIV_NW'(ma_s5) * DIV_NW'(VOLT_FULL2) + DIV_NW'(sum_s5);
			num_b_s6 <= DIV_NW'(mb_s5) * DIV_NW'(VOLT_FULL2) + DIV_NW'(sum_s5);
			num_t_s6 <= DIV_NW'(mn_w) * DIV_NW'(ATAN_SCALE);
			den_v_s6 <= {sum_s5, 1'b0};
			den_t_s6 <= DIV_DW'(mx_w);
			side_s6  <= '{zero: (sum_s5 == '0), neg_a: na_s5, neg_b: nb_s5,
				swap: swap_w};
		end
	end

	logic [DIV_QW-1:0] quo_a, quo_b, quo_t;
	foc_side_t         side_sd [DIV_QW];

	foc_div u_div_a (.clk(clk), .en(en[ST_DIV +: DIV_QW]), .num(num_a_s6),
		.den(den_v_s6), .quo(quo_a));
	foc_div u_div_b (.clk(clk), .en(en[ST_DIV +: DIV_QW]), .num(num_b_s6),
		.den(den_v_s6), .quo(quo_b));
	foc_div u_div_t (.clk(clk), .en(en[ST_DIV +: DIV_QW]), .num(num_t_s6),
		.den(den_t_s6), .quo(quo_t));

	for (genvar j = 0; j < DIV_QW; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[ST_DIV + j]) begin
				if (j == 0) side_sd[j] <= side_s6;
				else side_sd[j] <= side_sd[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// s7: sign restore, arctangent table lookup
	foc_side_t          side_w;
	logic [15:0]        qa_w, qb_w;
	logic [DIV_QW-17:0] ip_w;
	logic [ATAN_IW-1:0] idx_w;
	logic [15:0]        lo_w, hi_w;

	assign side_w = side_sd[DIV_QW-1];
	assign qa_w   = quo_a[15:0];
	assign qb_w   = quo_b[15:0];
	assign ip_w   = quo_t[DIV_QW-1:16];
	assign idx_w  = (ip_w > (DIV_QW-16)'(ATAN_STEPS)) ? ATAN_IW'(ATAN_STEPS)
		: ATAN_IW'(ip_w);
	assign lo_w   = ATAN_ROM[idx_w];
	assign hi_w   = ATAN_ROM[idx_w + ATAN_IW'(1)];

	logic signed [15:0] oa_s7, ob_s7;
	logic [15:0]        lo_s7, diff_s7, frac_s7;
	foc_side_t          side_s7;

	always_ff @(posedge clk) begin
		if (en[ST_S7]) begin
			oa_s7   <= side_w.zero ? '0 : (side_w.neg_a ? -qa_w : qa_w);
			ob_s7   <= side_w.zero ? '0 : (side_w.neg_b ? -qb_w : qb_w);
			lo_s7   <= lo_w;
			diff_s7 <= (hi_w < lo_w) ? '0 : hi_w - lo_w;
			frac_s7 <= quo_t[15:0];
			side_s7 <= side_w;
		end
	end

	// s8: interpolate, fold, round, sign
	logic [31:0] ip_prod;
	logic [16:0] fr_w, ang_w, fold_w;
	logic [14:0] ang15_w;

	assign ip_prod = 32'(diff_s7) * 32'(frac_s7);
	assign fr_w    = 17'((33'(ip_prod) + 33'd32768) >> 16);
	assign ang_w   = 17'(lo_s7) + fr_w;
	assign fold_w  = side_s7.swap ? 17'(HALF_PI_Q16) - ang_w : ang_w;
	assign ang15_w = 15'((18'(fold_w) + 18'd4) >> 3);

	logic signed [15:0] oa_s8, ob_s8;
	logic signed [14:0] ang_s8;
	logic               zero_s8;

	always_ff @(posedge clk) begin
		if (en[ST_S8]) begin
			oa_s8   <= oa_s7;
			ob_s8   <= ob_s7;
			ang_s8  <= side_s7.zero ? '0
				: ((side_s7.neg_a != side_s7.neg_b) ? -ang15_w : ang15_w);
			zero_s8 <= side_s7.zero;
		end
	end

	assign result.valid       = vld_q[PIPE_DEPTH-1];
	assign result.volt_alpha  = oa_s8;
	assign result.volt_beta   = ob_s8;
	assign result.space_angle = ang_s8;
	assign result.zero_vector = zero_s8;
endmodule
`default_nettype wire
